### rtl/core/fdl_pkg.sv
// Shared constants, types and an elaboration-time sine table function of the flanger delay line.
`default_nettype none

package fdl_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int BASE_W      = 20;
    localparam int DEPTH_W     = 20;
    localparam int STEP_W      = 16;
    localparam int LINE_LEN_W  = 13;
    localparam int PHASE_W     = 16;
    localparam int SINE_W      = 15;
    localparam int DLY_W       = 22;
    localparam int MAG_W       = 21;
    localparam int MUL_A_W     = 21;

    localparam int LINE_DEPTH_DEF   = 4096;
    localparam int SINE_ENTRIES_DEF = 256;
    localparam int FRAC_BITS_DEF    = 8;

    localparam logic [BASE_W-1:0]     BASE_RST  = BASE_W'(61440);
    localparam logic [DEPTH_W-1:0]    DEPTH_RST = DEPTH_W'(24576);
    localparam logic [STEP_W-1:0]     STEP_RST  = STEP_W'(1);
    localparam logic [LINE_LEN_W-1:0] LEN_RST   = LINE_LEN_W'(336);

    localparam logic [SINE_W-1:0] QUARTER_TURN = SINE_W'(16384);

    localparam int SAT_MAX = 32767;
    localparam int SAT_MIN = -32768;

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q15_MAX     = 64'sd32767;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_DELAY  = 2'd0,
        CFG_MOD_DEPTH   = 2'd1,
        CFG_PHASE_STEP  = 2'd2,
        CFG_LINE_LENGTH = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_stat;

    function automatic logic [SINE_W-1:0] sine_q15(input longint x);
        longint term;
        longint sum;
        longint v;
        term = x;
        sum  = x;
        for (int n = 1; n <= 6; n++) begin
            term = term * x / Q30_ONE;
            term = term * x / Q30_ONE;
            unique case (n)
                1:       term = -term / 64'sd6;
                2:       term = -term / 64'sd20;
                3:       term = -term / 64'sd42;
                4:       term = -term / 64'sd72;
                5:       term = -term / 64'sd110;
                default: term = -term / 64'sd156;
            endcase
            sum  = sum + term;
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum * Q15_MAX + Q30_ONE / 2) / Q30_ONE;
        if (v > Q15_MAX) begin
            v = Q15_MAX;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/flanger_delay_line_top.sv
// Flanger delay line: LFO-modulated, interpolated ring delay with output feedback.
// A new sample is taken only in the idle state, after the previous one has passed
// the 21-step remainder unit and the mix step has handed its result on.
// Reset: synchronous; after it the whole ring is cleared before the first sample
// is taken. Configuration writes are taken in every state outside reset.
`default_nettype none

module flanger_delay_line_top #(
    parameter int LINE_DEPTH         = fdl_pkg::LINE_DEPTH_DEF,
    parameter int SINE_TABLE_ENTRIES = fdl_pkg::SINE_ENTRIES_DEF,
    parameter int FRAC_BITS          = fdl_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [fdl_pkg::SAMPLE_W-1:0]  i_sample_in,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic signed      [fdl_pkg::SAMPLE_W-1:0]  o_sample_out,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic        [fdl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic        [fdl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import fdl_pkg::*;

    localparam int AW      = $clog2(LINE_DEPTH);
    localparam int LEN_W   = AW + 1;
    localparam int CMP_W   = (LEN_W > LINE_LEN_W) ? LEN_W : LINE_LEN_W;
    localparam int RING_W  = LEN_W + FRAC_BITS;
    localparam int PSW     = RING_W + 2;
    localparam int TW      = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int IDXP_W  = SINE_W + TW;
    localparam int MB_W    = (FRAC_BITS + 2 > SAMPLE_W) ? FRAC_BITS + 2 : SAMPLE_W;
    localparam int PW      = MUL_A_W + MB_W;

    localparam logic signed [PW-1:0] TZ_BIAS = PW'((1 << (FRAC_BITS + 1)) - 1);
    localparam logic signed [PW-1:0] Q_MAX   = PW'(SAT_MAX);
    localparam logic signed [PW-1:0] Q_MIN   = PW'(SAT_MIN);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_MOD   = 10'b0000000100,
        S_DLY   = 10'b0000001000,
        S_DIV   = 10'b0000010000,
        S_POS   = 10'b0000100000,
        S_RDA   = 10'b0001000000,
        S_RDB   = 10'b0010000000,
        S_MULB  = 10'b0100000000,
        S_MIX   = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [BASE_W-1:0]     r_base_delay;
    logic [DEPTH_W-1:0]    r_mod_depth;
    logic [STEP_W-1:0]     r_phase_step;
    logic [LINE_LEN_W-1:0] r_line_length;

    logic [AW-1:0]         r_clr_addr;
    logic [AW-1:0]         r_wp;
    logic [PHASE_W-1:0]    r_lfo_phase;
    logic                  r_out_valid;
    logic [SAMPLE_W-1:0]   r_sample_out;

    logic signed [SAMPLE_W-1:0] r_x;
    logic [SINE_W-1:0]     r_mag;
    logic                  r_neg;
    logic [LEN_W-1:0]      r_len;
    logic                  r_dneg;
    logic [AW-1:0]         r_i1;
    logic [AW-1:0]         r_i2;
    logic [FRAC_BITS-1:0]  r_frac;
    logic signed [PW-1:0]  r_prod;
    logic signed [PW-1:0]  r_acc;

    // sine table
    logic [SINE_W-1:0] sine_tab [SINE_TABLE_ENTRIES + 1];

    for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_sine
        localparam longint XK = (longint'(k) * Q30_HALF_PI) / SINE_TABLE_ENTRIES;
        assign sine_tab[k] = sine_q15(XK);
    end

    logic [SINE_W-1:0] lfo_pos;
    logic [IDXP_W-1:0] lfo_idx_prod;
    logic [TW-1:0]     lfo_idx;

    assign lfo_pos      = r_lfo_phase[PHASE_W-2] ?
                          QUARTER_TURN - {1'b0, r_lfo_phase[PHASE_W-3:0]} :
                          {1'b0, r_lfo_phase[PHASE_W-3:0]};
    assign lfo_idx_prod = IDXP_W'(lfo_pos) * IDXP_W'(SINE_TABLE_ENTRIES);
    assign lfo_idx      = lfo_idx_prod[SINE_W-1 +: TW];

    // effective line length
    logic [CMP_W-1:0] len_cmp;
    logic [LEN_W-1:0] len_eff;

    assign len_cmp = CMP_W'(r_line_length);

    always_comb begin
        priority if (r_line_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (len_cmp > CMP_W'(LINE_DEPTH)) begin
            len_eff = LEN_W'(LINE_DEPTH);
        end else begin
            len_eff = LEN_W'(len_cmp);
        end
    end

    // handshakes
    logic in_acc;
    logic mix_go;

    assign o_ready     = (r_state == S_IDLE);
    assign in_acc      = i_valid && o_ready;
    assign mix_go      = !r_out_valid || i_ready;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_sample_out = r_sample_out;

    // delay and its magnitude
    logic [DEPTH_W-1:0]       modv;
    logic signed [DLY_W-1:0]  dly;
    logic [MAG_W-1:0]         dly_mag;

    assign modv    = r_prod[SINE_W +: DEPTH_W];
    assign dly     = r_neg ? DLY_W'(r_base_delay) - DLY_W'(modv) :
                             DLY_W'(r_base_delay) + DLY_W'(modv);
    assign dly_mag = dly[DLY_W-1] ? MAG_W'(-dly) : MAG_W'(dly);

    // remainder unit
    logic [RING_W-1:0] ring;
    logic [RING_W-1:0] rem_val;
    t_rem_stat         rem_stat;
    logic              rem_start;

    assign ring      = {r_len, {FRAC_BITS{1'b0}}};
    assign rem_start = (r_state == S_DLY);

    fdl_rem #(
        .DVD_W (MAG_W),
        .DVS_W (RING_W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (dly_mag),
        .i_divisor  (ring),
        .o_stat     (rem_stat),
        .o_rem      (rem_val)
    );

    // read position
    logic signed [PSW-1:0] wp_s;
    logic signed [PSW-1:0] ring_s;
    logic signed [PSW-1:0] rem_s;
    logic signed [PSW-1:0] pos0;
    logic signed [PSW-1:0] pos;

    assign wp_s   = PSW'({r_wp, {FRAC_BITS{1'b0}}});
    assign ring_s = PSW'(ring);
    assign rem_s  = PSW'(rem_val);
    assign pos0   = r_dneg ? wp_s + rem_s : wp_s - rem_s;

    always_comb begin
        if (r_dneg) begin
            pos = (pos0 >= ring_s) ? pos0 - ring_s : pos0;
        end else begin
            pos = (pos0 < 0) ? pos0 + ring_s : pos0;
        end
    end

    logic [LEN_W-1:0] i1_nx;

    assign i1_nx = LEN_W'(r_i1) + LEN_W'(1);

    // delay store
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [SAMPLE_W-1:0]        ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SAMPLE_W-1:0] rdata_s;

    assign rdata_s = ram_rdata;

    fdl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LINE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PW-1:0]      mul_p;
    logic [FRAC_BITS:0]        weight_a;

    assign weight_a = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, r_frac};

    always_comb begin
        unique case (r_state)
            S_MOD: begin
                mul_a = MUL_A_W'({1'b0, r_mod_depth});
                mul_b = MB_W'({1'b0, r_mag});
            end
            S_RDB: begin
                mul_a = MUL_A_W'(rdata_s);
                mul_b = MB_W'({1'b0, weight_a});
            end
            S_MULB: begin
                mul_a = MUL_A_W'(rdata_s);
                mul_b = MB_W'({1'b0, r_frac});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // mix, truncate toward zero, saturate
    logic signed [PW-1:0] interp;
    logic signed [PW-1:0] mix_sum;
    logic signed [PW-1:0] mix_adj;
    logic signed [PW-1:0] mix_q;
    logic [SAMPLE_W-1:0]  mix_out;

    assign interp  = r_acc + r_prod;
    assign mix_sum = (PW'(r_x) <<< FRAC_BITS) + interp;
    assign mix_adj = mix_sum[PW-1] ? mix_sum + TZ_BIAS : mix_sum;
    assign mix_q   = mix_adj >>> (FRAC_BITS + 1);

    always_comb begin
        priority if (mix_q > Q_MAX) begin
            mix_out = SAMPLE_W'(Q_MAX);
        end else if (mix_q < Q_MIN) begin
            mix_out = SAMPLE_W'(Q_MIN);
        end else begin
            mix_out = SAMPLE_W'(mix_q);
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wp;
        ram_wdata = mix_out;
        ram_raddr = r_i1;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            S_RDB: begin
                ram_raddr = r_i2;
            end
            S_MIX: begin
                ram_we = mix_go;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(LINE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_MOD;
                end
            end
            S_MOD:  n_state = S_DLY;
            S_DLY:  n_state = S_DIV;
            S_DIV: begin
                if (rem_stat.done) begin
                    n_state = S_POS;
                end
            end
            S_POS:  n_state = S_RDA;
            S_RDA:  n_state = S_RDB;
            S_RDB:  n_state = S_MULB;
            S_MULB: n_state = S_MIX;
            S_MIX: begin
                if (mix_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_wp          <= '0;
            r_lfo_phase   <= '0;
            r_out_valid   <= 1'b0;
            r_base_delay  <= BASE_RST;
            r_mod_depth   <= DEPTH_RST;
            r_phase_step  <= STEP_RST;
            r_line_length <= LEN_RST;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (in_acc && LEN_W'(r_wp) >= len_eff) begin
                r_wp <= '0;
            end
            if (r_state == S_MIX && mix_go) begin
                r_wp        <= (LEN_W'(r_wp) + LEN_W'(1) >= r_len) ? '0 : r_wp + AW'(1);
                r_lfo_phase <= r_lfo_phase + r_phase_step;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_BASE_DELAY:  r_base_delay  <= i_cfg_data[BASE_W-1:0];
                    CFG_MOD_DEPTH:   r_mod_depth   <= i_cfg_data[DEPTH_W-1:0];
                    CFG_PHASE_STEP:  r_phase_step  <= i_cfg_data[STEP_W-1:0];
                    CFG_LINE_LENGTH: r_line_length <= i_cfg_data[LINE_LEN_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x   <= i_sample_in;
            r_mag <= sine_tab[lfo_idx];
            r_neg <= r_lfo_phase[PHASE_W-1];
            r_len <= len_eff;
        end
        if (r_state == S_MOD) begin
            r_prod <= mul_p;
        end
        if (r_state == S_DLY) begin
            r_dneg <= dly[DLY_W-1];
        end
        if (r_state == S_POS) begin
            r_i1   <= pos[FRAC_BITS +: AW];
            r_frac <= pos[FRAC_BITS-1:0];
        end
        if (r_state == S_RDA) begin
            r_i2 <= (i1_nx >= r_len) ? '0 : AW'(i1_nx);
        end
        if (r_state == S_RDB) begin
            r_prod <= mul_p;
        end
        if (r_state == S_MULB) begin
            r_acc  <= r_prod;
            r_prod <= mul_p;
        end
        if (r_state == S_MIX && mix_go) begin
            r_sample_out <= mix_out;
        end
    end

`ifndef SYNTHESIS
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready)
        else $error("request taken while previous one still in work");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POS) |-> (rem_val < ring))
        else $error("remainder not below ring size");

    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX && mix_go) |=> (LEN_W'(r_wp) < r_len))
        else $error("write pointer beyond line length");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_MIX))
        else $error("result raised outside the mix step");
`endif

endmodule

`default_nettype wire

### rtl/core/fdl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fdl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/fdl_rem.sv
// Iterative restoring remainder unit, one dividend bit per cycle.
`default_nettype none

module fdl_rem #(
    parameter int DVD_W = 21,
    parameter int DVS_W = 21
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [DVD_W-1:0]   i_dividend,
    input  wire logic [DVS_W-1:0]   i_divisor,
    output fdl_pkg::t_rem_stat      o_stat,
    output logic      [DVS_W-1:0]   o_rem
);

    import fdl_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             take;

    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign take  = trial >= {1'b0, i_divisor};
    assign diff  = trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && (r_cnt == '0);
    assign o_rem       = r_rem;

endmodule

`default_nettype wire
